// ----- rtl/gre_pkg.sv -----
// Shared types, constants and helper functions of the graph reachability engine.
package gre_pkg;

    localparam int NUM_VERTICES = 256;
    localparam int V_W          = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int CNT_W        = $clog2(NUM_VERTICES + 1);
    localparam logic [8:0] SIZE_MAX = 9'h1FF;

    typedef logic [NUM_VERTICES-1:0] t_row;
    typedef logic [V_W-1:0]          t_vid;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_SIZE  = 2'd1,
        REQ_REACH = 2'd2,
        REQ_ADJ   = 2'd3
    } t_req;

    typedef struct packed {
        t_req       req_type;
        logic [7:0] vertex_a;
        logic [7:0] vertex_b;
    } t_item;

    typedef struct packed {
        logic [8:0] component_size;
        logic       reachable;
        logic       adjacent;
    } t_result;

    typedef struct packed {
        logic we;
        t_vid addr;
        t_row data;
    } t_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_A,
        ST_ADD_B,
        ST_ADJ,
        ST_WALK
    } t_state;

    function automatic logic in_range(input logic [7:0] v);
        return (32'(v) < NUM_VERTICES);
    endfunction

    function automatic t_vid to_vid(input logic [7:0] v);
        return V_W'(v);
    endfunction

    function automatic t_row onehot(input t_vid v);
        return t_row'(1) << v;
    endfunction

endpackage

// ----- rtl/gre_adj_mem.sv -----
// Adjacency row memory with one write port, one registered read port and per-row valid bits.
module gre_adj_mem
    import gre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_wr  i_wr,
    input  t_vid i_raddr,
    output t_row o_rdata
);

    t_row r_mem [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] r_row_vld;
    t_row r_q;
    logic r_q_vld;

    // A row that was never written reads as all zeros.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_q_vld   <= 1'b0;
        end else begin
            r_q_vld <= r_row_vld[i_raddr];
            if (i_wr.we) begin
                r_row_vld[i_wr.addr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_q_vld ? r_q : '0;

endmodule

// ----- rtl/gre_pick.sv -----
// Selects the lowest pending vertex and encodes its index.
module gre_pick
    import gre_pkg::*;
(
    input  t_row i_pending,
    output logic o_found,
    output t_row o_bit,
    output t_vid o_idx
);

    // Two's complement trick isolates the lowest set bit.
    assign o_bit   = i_pending & (~i_pending + t_row'(1));
    assign o_found = |i_pending;

    always_comb begin
        o_idx = '0;
        for (int i = 0; i < NUM_VERTICES; i++) begin
            if (o_bit[i]) begin
                o_idx = o_idx | V_W'(i);
            end
        end
    end

endmodule

// ----- rtl/graph_reachability_engine.sv -----
// Top level: request sequencer and flood walk around the adjacency row memory.
// Add edge keeps busy through ST_ADD_A and ST_ADD_B after acceptance and gives no result.
// An adjacency query strobes its result from ST_ADJ through the registered done flag.
// A component-size or reachability query strobes its result once the flood walk is complete;
// the walk reads one row per cycle, plus a bubble whenever it waits on a row to find a vertex.
// A new item is taken in the strobe cycle. Synchronous reset clears all rows via valid bits.
module graph_reachability_engine
    import gre_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_result
);

    // Control and walk state.
    t_state r_state, n_state;
    t_req   r_req, n_req;
    t_vid   r_a, n_a;
    t_vid   r_b, n_b;
    t_row   r_visited, n_visited;
    t_row   r_pending, n_pending;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic   r_inflight, n_inflight;
    logic   r_done, n_done;
    t_result r_res, n_res;

    // Memory interface.
    t_wr    wr;
    t_vid   rd_addr;
    t_row   rd_row;
    t_row   fresh;

    // Pending-vertex selection.
    logic   pick_found;
    t_row   pick_bit;
    t_vid   pick_idx;

    logic   accept;
    logic   ok_a;
    logic   ok_b;

    gre_adj_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_raddr (rd_addr),
        .o_rdata (rd_row)
    );

    gre_pick u_pick (
        .i_pending (r_pending),
        .o_found   (pick_found),
        .o_bit     (pick_bit),
        .o_idx     (pick_idx)
    );

    assign accept = i_start && (r_state == ST_IDLE);
    assign ok_a   = in_range(i_item.vertex_a);
    assign ok_b   = in_range(i_item.vertex_b);

    // Neighbors of the row that arrived this cycle which the walk has not seen yet.
    assign fresh = rd_row & ~r_visited;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_inflight <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_inflight <= n_inflight;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_a       <= n_a;
        r_b       <= n_b;
        r_visited <= n_visited;
        r_pending <= n_pending;
        r_cnt     <= n_cnt;
        r_res     <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_a        = r_a;
        n_b        = r_b;
        n_visited  = r_visited;
        n_pending  = r_pending;
        n_cnt      = r_cnt;
        n_inflight = 1'b0;
        n_done     = 1'b0;
        n_res      = '0;
        rd_addr    = r_a;
        wr         = '0;

        case (r_state)
            ST_IDLE: begin
                // The read of row a is issued on acceptance; the add-edge and adjacency
                // paths consume it in the next cycle, the walk ignores it.
                rd_addr = to_vid(i_item.vertex_a);
                if (accept) begin
                    n_req     = i_item.req_type;
                    n_a       = to_vid(i_item.vertex_a);
                    n_b       = to_vid(i_item.vertex_b);
                    n_visited = onehot(to_vid(i_item.vertex_a));
                    n_pending = onehot(to_vid(i_item.vertex_a));
                    n_cnt     = '0;
                    case (i_item.req_type)
                        REQ_ADD: begin
                            if (ok_a && ok_b) begin
                                n_state = ST_ADD_A;
                            end
                        end
                        REQ_SIZE: begin
                            if (ok_a) begin
                                n_state = ST_WALK;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        REQ_REACH: begin
                            if (ok_a && ok_b) begin
                                n_state = ST_WALK;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        REQ_ADJ: begin
                            if (ok_a && ok_b) begin
                                n_state = ST_ADJ;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ADD_A: begin
                // Write back row a with bit b set and fetch row b. When a equals b the
                // read returns the old row, and the second write sets the same bit again.
                wr.we   = 1'b1;
                wr.addr = r_a;
                wr.data = rd_row | onehot(r_b);
                rd_addr = r_b;
                n_state = ST_ADD_B;
            end

            ST_ADD_B: begin
                wr.we   = 1'b1;
                wr.addr = r_b;
                wr.data = rd_row | onehot(r_a);
                n_state = ST_IDLE;
            end

            ST_ADJ: begin
                n_done         = 1'b1;
                n_res.adjacent = rd_row[r_b];
                n_state        = ST_IDLE;
            end

            ST_WALK: begin
                // In each cycle that a vertex is pending, one leaves the pending set and
                // its row is read; the row returns in the next cycle and merges its new
                // neighbors.
                if (r_inflight) begin
                    n_visited = r_visited | fresh;
                    n_pending = (r_pending & ~pick_bit) | fresh;
                end else begin
                    n_pending = r_pending & ~pick_bit;
                end
                if (pick_found) begin
                    rd_addr    = pick_idx;
                    n_inflight = 1'b1;
                    n_cnt      = r_cnt + CNT_W'(1);
                end else if (!r_inflight) begin
                    // Nothing pending and no row outstanding: the flood is complete,
                    // and every visited vertex was picked exactly once.
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_req == REQ_SIZE) begin
                        n_res.component_size = (32'(r_cnt) > 32'(SIZE_MAX)) ?
                                               SIZE_MAX : 9'(r_cnt);
                    end else begin
                        n_res.reachable = r_visited[r_b];
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
